// ===== sv/mmsb_pkg.sv =====
// ----------------------------------------------------------------------------
// mmsb_pkg
// Shared types and constants of the pair sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package mmsb_pkg;

  localparam int unsigned MAX_USERS  = 64;
  localparam int unsigned MAX_K      = 8;
  localparam int unsigned USR_W      = 6;
  localparam int unsigned CL_W       = 3;
  localparam int unsigned KCNT_W     = 4;
  localparam int unsigned PAIR_W     = 2 * CL_W;
  localparam int unsigned PA_AW      = 2 * USR_W + 1;
  localparam int unsigned BC_W       = 12;
  localparam int unsigned UC_W       = 7;
  localparam int unsigned PRIOR_W    = 16;
  localparam int unsigned NUM_W      = 22;
  localparam int unsigned RAT_W      = 25;
  localparam int unsigned FAC_W      = 17;
  localparam int unsigned WGT_W      = 43;
  localparam int unsigned TOT_W      = 49;
  localparam int unsigned MUL_W      = 32;
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_ITERS  = 6;
  localparam int unsigned DIV_CNT_W  = 3;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIOR_ABSENT     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIOR_PRESENT    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEMBERSHIP_PRIOR = 4'd3;

  localparam logic [KCNT_W-1:0]  RST_CLUSTER_COUNT = 4'd3;
  localparam logic [PRIOR_W-1:0] RST_PRIOR         = 16'd26;

  localparam logic OP_INIT     = 1'b0;
  localparam logic OP_RESAMPLE = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [USR_W-1:0]  sender;
    logic [USR_W-1:0]  receiver;
    logic              link;
    logic [31:0]       random_draw;
  } in_item_t;

  typedef struct packed {
    logic [CL_W-1:0] sender_cluster;
    logic [CL_W-1:0] receiver_cluster;
    logic            skipped;
  } out_item_t;

  typedef logic [1:0][BC_W-1:0]       bc_entry_t;
  typedef logic [MAX_K-1:0][UC_W-1:0] uc_row_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RDP,
    S_RDQ,
    S_PA0,
    S_PA1,
    S_PA2,
    S_DEC,
    S_WRD,
    S_WDIV,
    S_WWAIT,
    S_WM1,
    S_WM2,
    S_WM3,
    S_WM4,
    S_TM1,
    S_TM2,
    S_TM3,
    S_SRD,
    S_SCMP,
    S_IM1,
    S_IM2,
    S_IM3,
    S_UPD_RD,
    S_UPD_WB,
    S_UPD_WQ,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== sv/mmsb_mul.sv =====
// ----------------------------------------------------------------------------
// mmsb_mul
// Shared 32 x 32 multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module mmsb_mul import mmsb_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic [MUL_W-1:0]   a_i,
  input  wire logic [MUL_W-1:0]   b_i,
  output logic      [2*MUL_W-1:0] p_o
);

  logic [2*MUL_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= {{MUL_W{1'b0}}, a_i} * {{MUL_W{1'b0}}, b_i};
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== sv/mmsb_ratio_div.sv =====
// ----------------------------------------------------------------------------
// mmsb_ratio_div
// Iterative Q1.24 ratio divider, num <= den, four quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mmsb_ratio_div import mmsb_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [NUM_W-1:0] den_i,
  output logic                  done_o,
  output logic      [RAT_W-1:0] quo_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0]     rem_q, rem_d;
  logic [NUM_W-1:0]     den_q;
  logic [RAT_W-1:0]     quo_q, quo_d;
  logic [NUM_W:0]       r2;
  logic                 q0;

  assign q0 = (num_i >= den_i);

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    r2    = '0;
    for (int j = 0; j < DIV_STEPS; j++) begin
      r2 = {rem_d, 1'b0};
      if (r2 >= {1'b0, den_q}) begin
        rem_d = NUM_W'(r2 - {1'b0, den_q});
        quo_d = {quo_d[RAT_W-2:0], 1'b1};
      end else begin
        rem_d = r2[NUM_W-1:0];
        quo_d = {quo_d[RAT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (den_i == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_ITERS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      if (den_i == '0) begin
        quo_q <= '0;
        rem_q <= '0;
      end else begin
        rem_q <= q0 ? (num_i - den_i) : num_i;
        quo_q <= {{(RAT_W-1){1'b0}}, q0};
      end
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

  cnt_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q < DIV_CNT_W'(DIV_ITERS)) else $error("divider count overrun");
  done_pulse_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q || $past(start_i)) else $error("divider done held");
  busy_done_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");

endmodule

`default_nettype wire

// ===== sv/mmsb_gibbs_pair_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// mmsb_gibbs_pair_sampler_unit
// Collapsed Gibbs cluster-pair sampler for one ordered user pair per item.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid_i / in_stall_o, one result per item leaves on
// out_valid_o / out_stall_i; a transfer happens when valid is high and stall
// low. Registers are written on cfg_valid_i / cfg_ready_o; the user must write
// them only while idle, since the block does not enforce it. The block takes one
// item at a time and stalls its input until done. A resample item weighs every
// cluster pair of the K clusters in use, then scans from 1 to K*K of them. Per
// cluster pair the weight takes one count read, a divider start and a wait on
// the ratio divider (6 steps of 4 quotient bits; a zero denominator skips the
// steps) and the shared multiplier; the draw then scans the stored weights pair
// by pair.
// Reset clears all block and user counts at once through row valid bits and
// loads the register defaults; no clearing pass is needed.
// A finished result sits in the output register while the receiver stalls;
// the next item is accepted meanwhile and waits only at its own hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module mmsb_gibbs_pair_sampler_unit import mmsb_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [KCNT_W-1:0]  cluster_count_q;
  logic [PRIOR_W-1:0] prior_absent_q, prior_present_q, membership_prior_q;
  logic [KCNT_W-1:0]  k_act, k_m1;

  logic             op_q, y_q, skip_q;
  logic [USR_W-1:0] p_q, q_q;
  logic [31:0]      u_q;
  logic [CL_W-1:0]  g_old_q, h_old_q, g_q, h_q, g_new_q, h_new_q;
  logic [PAIR_W-1:0] idx_q;
  uc_row_t          rowp_q, rowq_q;
  logic [RAT_W-1:0] ratio_q;
  logic [FAC_W-1:0] fp_q, fq_q;
  logic [9:0]       t1hi_q;
  logic [TOT_W-1:0] acc_q, total_q, thr_q, run_q, run_sum;
  logic [WGT_W+15:0] full_w;
  logic [WGT_W-1:0] weight;
  logic             last_pair, scan_hit;

  logic [CL_W-1:0]  pa_mem [2**PA_AW];
  logic [CL_W-1:0]  pa_rd_q;
  bc_entry_t        bc_mem [MAX_K*MAX_K];
  logic [MAX_K*MAX_K-1:0] bc_vld_q;
  bc_entry_t        bc_rd_q;
  uc_row_t          uc_mem [MAX_USERS];
  logic [MAX_USERS-1:0] uc_vld_q;
  uc_row_t          uc_rd_q;
  logic [WGT_W-1:0] w_mem [MAX_K*MAX_K];
  logic [WGT_W-1:0] w_rd_q;

  logic [PA_AW-1:0]  pa_raddr, pa_waddr;
  logic              pa_we;
  logic [CL_W-1:0]   pa_wdata;
  logic [PAIR_W-1:0] bc_raddr, bc_waddr;
  logic              bc_we;
  bc_entry_t         bc_wdata;
  logic [USR_W-1:0]  uc_raddr, uc_waddr;
  logic              uc_we;
  uc_row_t           uc_wdata;
  logic              w_we;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;
  logic              div_start, div_done;
  logic [RAT_W-1:0]  div_quo;
  logic [NUM_W-1:0]  div_num, div_den;

  logic      in_fire;
  logic      out_load;
  logic      out_valid_q;
  out_item_t out_data_q;

  assign cfg_ready_o = 1'b1;
  assign k_act = (cluster_count_q == '0) ? KCNT_W'(1) :
                 (cluster_count_q > KCNT_W'(MAX_K)) ? KCNT_W'(MAX_K) : cluster_count_q;
  assign k_m1  = k_act - 1'b1;
  assign last_pair = ({1'b0, g_q} == k_m1) && ({1'b0, h_q} == k_m1);

  assign in_fire  = in_valid_i && (state_q == S_IDLE);
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign div_num = NUM_W'({bc_rd_q[y_q], 8'b0}) +
                   NUM_W'(y_q ? prior_present_q : prior_absent_q);
  assign div_den = NUM_W'({({1'b0, bc_rd_q[0]} + {1'b0, bc_rd_q[1]}), 8'b0}) +
                   NUM_W'(prior_absent_q) + NUM_W'(prior_present_q);

  assign full_w  = (WGT_W+16)'({mul_p[26:0], 32'b0}) + (WGT_W+16)'(acc_q);
  assign weight  = full_w[WGT_W+15:16];
  assign run_sum = run_q + TOT_W'(w_rd_q);
  assign scan_hit = (run_sum > thr_q);

  mmsb_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  mmsb_ratio_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) begin
                  state_d = (in_data_i.sender == in_data_i.receiver) ? S_DONE : S_RDP;
                end
      S_RDP:    state_d = S_RDQ;
      S_RDQ:    state_d = S_PA0;
      S_PA0:    state_d = (op_q == OP_INIT) ? S_IM1 : S_PA1;
      S_PA1:    state_d = S_PA2;
      S_PA2:    state_d = S_DEC;
      S_DEC:    state_d = S_WRD;
      S_WRD:    state_d = S_WDIV;
      S_WDIV:   state_d = S_WWAIT;
      S_WWAIT:  if (div_done) begin
                  state_d = S_WM1;
                end
      S_WM1:    state_d = S_WM2;
      S_WM2:    state_d = S_WM3;
      S_WM3:    state_d = S_WM4;
      S_WM4:    state_d = last_pair ? S_TM1 : S_WRD;
      S_TM1:    state_d = S_TM2;
      S_TM2:    state_d = S_TM3;
      S_TM3:    state_d = S_SRD;
      S_SRD:    state_d = S_SCMP;
      S_SCMP:   state_d = (scan_hit || last_pair) ? S_UPD_RD : S_SRD;
      S_IM1:    state_d = S_IM2;
      S_IM2:    state_d = S_IM3;
      S_IM3:    state_d = S_UPD_RD;
      S_UPD_RD: state_d = S_UPD_WB;
      S_UPD_WB: state_d = S_UPD_WQ;
      S_UPD_WQ: state_d = S_DONE;
      S_DONE:   if (out_load) begin
                  state_d = S_IDLE;
                end
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    pa_raddr   = {p_q, q_q, 1'b0};
    pa_we      = 1'b0;
    pa_waddr   = {p_q, q_q, 1'b0};
    pa_wdata   = g_new_q;
    bc_raddr   = {g_q, h_q};
    bc_we      = 1'b0;
    bc_waddr   = {g_new_q, h_new_q};
    bc_wdata   = bc_rd_q;
    uc_raddr   = p_q;
    uc_we      = 1'b0;
    uc_waddr   = p_q;
    uc_wdata   = rowp_q;
    w_we       = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    case (state_q)
      S_RDQ:    uc_raddr = q_q;
      S_PA1:    pa_raddr = {q_q, p_q, 1'b1};
      S_PA2:    bc_raddr = {g_old_q, pa_rd_q};
      S_DEC: begin
        bc_we    = 1'b1;
        bc_waddr = {g_old_q, h_old_q};
        bc_wdata[y_q] = bc_rd_q[y_q] - 1'b1;
      end
      S_WDIV:   div_start = 1'b1;
      S_WM1: begin
        mul_a = MUL_W'(ratio_q);
        mul_b = MUL_W'(fp_q);
      end
      S_WM2: begin
        mul_a = mul_p[MUL_W-1:0];
        mul_b = MUL_W'(fq_q);
      end
      S_WM3: begin
        mul_a = MUL_W'(t1hi_q);
        mul_b = MUL_W'(fq_q);
      end
      S_WM4:    w_we = 1'b1;
      S_TM1: begin
        mul_a = total_q[MUL_W-1:0];
        mul_b = u_q;
      end
      S_TM2: begin
        mul_a = MUL_W'(total_q[TOT_W-1:MUL_W]);
        mul_b = u_q;
      end
      S_IM1: begin
        mul_a = u_q;
        mul_b = MUL_W'(k_act);
      end
      S_IM2: begin
        mul_a = mul_p[MUL_W-1:0];
        mul_b = MUL_W'(k_act);
      end
      S_UPD_RD: begin
        bc_raddr = {g_new_q, h_new_q};
        pa_we    = 1'b1;
      end
      S_UPD_WB: begin
        bc_we    = 1'b1;
        bc_wdata[y_q] = bc_rd_q[y_q] + 1'b1;
        pa_we    = 1'b1;
        pa_waddr = {q_q, p_q, 1'b1};
        pa_wdata = h_new_q;
        uc_we    = 1'b1;
      end
      S_UPD_WQ: begin
        uc_we    = 1'b1;
        uc_waddr = q_q;
        uc_wdata = rowq_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= S_IDLE;
      cluster_count_q    <= RST_CLUSTER_COUNT;
      prior_absent_q     <= RST_PRIOR;
      prior_present_q    <= RST_PRIOR;
      membership_prior_q <= RST_PRIOR;
      bc_vld_q           <= '0;
      uc_vld_q           <= '0;
      out_valid_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_CLUSTER_COUNT:    cluster_count_q    <= cfg_data_i[KCNT_W-1:0];
          CFG_PRIOR_ABSENT:     prior_absent_q     <= cfg_data_i;
          CFG_PRIOR_PRESENT:    prior_present_q    <= cfg_data_i;
          CFG_MEMBERSHIP_PRIOR: membership_prior_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (bc_we) begin
        bc_vld_q[bc_waddr] <= 1'b1;
      end
      if (uc_we) begin
        uc_vld_q[uc_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pa_rd_q <= pa_mem[pa_raddr];
    if (pa_we) begin
      pa_mem[pa_waddr] <= pa_wdata;
    end
    bc_rd_q <= bc_vld_q[bc_raddr] ? bc_mem[bc_raddr] : '0;
    if (bc_we) begin
      bc_mem[bc_waddr] <= bc_wdata;
    end
    uc_rd_q <= uc_vld_q[uc_raddr] ? uc_mem[uc_raddr] : '0;
    if (uc_we) begin
      uc_mem[uc_waddr] <= uc_wdata;
    end
    w_rd_q <= w_mem[idx_q];
    if (w_we) begin
      w_mem[idx_q] <= weight;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.sender_cluster   <= g_new_q;
      out_data_q.receiver_cluster <= h_new_q;
      out_data_q.skipped          <= skip_q;
    end
    case (state_q)
      S_IDLE: if (in_fire) begin
        op_q    <= in_data_i.operation;
        p_q     <= in_data_i.sender;
        q_q     <= in_data_i.receiver;
        y_q     <= in_data_i.link;
        u_q     <= in_data_i.random_draw;
        skip_q  <= (in_data_i.sender == in_data_i.receiver);
        g_new_q <= '0;
        h_new_q <= '0;
      end
      S_RDQ:  rowp_q <= uc_rd_q;
      S_PA0:  rowq_q <= uc_rd_q;
      S_PA1:  g_old_q <= pa_rd_q;
      S_PA2: begin
        h_old_q <= pa_rd_q;
        rowp_q[g_old_q] <= rowp_q[g_old_q] - 1'b1;
        rowq_q[pa_rd_q] <= rowq_q[pa_rd_q] - 1'b1;
      end
      S_DEC: begin
        g_q     <= '0;
        h_q     <= '0;
        idx_q   <= '0;
        total_q <= '0;
      end
      S_WDIV: begin
        fp_q <= FAC_W'({rowp_q[g_q], 8'b0}) + FAC_W'(membership_prior_q);
        fq_q <= FAC_W'({rowq_q[h_q], 8'b0}) + FAC_W'(membership_prior_q);
      end
      S_WWAIT: ratio_q <= div_quo;
      S_WM2:  t1hi_q <= mul_p[41:32];
      S_WM3:  acc_q  <= mul_p[TOT_W-1:0];
      S_WM4: begin
        total_q <= total_q + TOT_W'(weight);
        idx_q   <= idx_q + 1'b1;
        if ({1'b0, h_q} == k_m1) begin
          h_q <= '0;
          g_q <= g_q + 1'b1;
        end else begin
          h_q <= h_q + 1'b1;
        end
      end
      S_TM2:  thr_q <= TOT_W'(mul_p[2*MUL_W-1:MUL_W]);
      S_TM3: begin
        thr_q <= thr_q + mul_p[TOT_W-1:0];
        run_q <= '0;
        idx_q <= '0;
        g_q   <= '0;
        h_q   <= '0;
      end
      S_SCMP: begin
        run_q <= run_sum;
        idx_q <= idx_q + 1'b1;
        if (scan_hit) begin
          g_new_q <= g_q;
          h_new_q <= h_q;
        end else if (last_pair) begin
          g_new_q <= '0;
          h_new_q <= '0;
        end else if ({1'b0, h_q} == k_m1) begin
          h_q <= '0;
          g_q <= g_q + 1'b1;
        end else begin
          h_q <= h_q + 1'b1;
        end
      end
      S_IM2:  g_new_q <= mul_p[MUL_W+CL_W-1:MUL_W];
      S_IM3:  h_new_q <= mul_p[MUL_W+CL_W-1:MUL_W];
      S_UPD_RD: begin
        rowp_q[g_new_q] <= rowp_q[g_new_q] + 1'b1;
        rowq_q[h_new_q] <= rowq_q[h_new_q] + 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  div_owner_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_WWAIT) else $error("divider result outside wait");
  skip_zero_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.skipped) |->
      (out_data_o.sender_cluster == '0 && out_data_o.receiver_cluster == '0))
    else $error("skipped result carries clusters");
  scan_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCMP || state_q == S_WM4) |->
      ({1'b0, g_q} <= k_m1 && {1'b0, h_q} <= k_m1))
    else $error("pair counter beyond cluster count");
  load_free_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && state_q == S_IDLE) else $error("result not loaded");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the collapsed Gibbs pair sampler: a queue-fed driver
// and a monitor with random gaps and stalls; every accepted item is predicted
// against a bit-accurate model of the counts, weights and draw.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import mmsb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 10000000;
  localparam int unsigned PHASES      = 8;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mmsb_gibbs_pair_sampler_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sampler state as predicted
  logic [KCNT_W-1:0]  k_reg;
  logic [PRIOR_W-1:0] prior_abs, prior_pres, memb_prior;
  logic [CL_W-1:0]    assign_mem [MAX_USERS*MAX_USERS*2];
  logic [BC_W-1:0]    link_cnt [MAX_K*MAX_K*2];
  logic [UC_W-1:0]    member_cnt [MAX_USERS*MAX_K];
  bit                 pair_seeded [MAX_USERS][MAX_USERS];

  in_item_t  pending_items [$];
  out_item_t cluster_pick_q [$];
  int unsigned err_cnt = 0, n_acc = 0, n_resample = 0, n_skip = 0, n_out = 0;
  int unsigned n_added = 0;
  int unsigned cycles = 0, gap = 0, stall_cnt = 0;
  logic hold_req = 1'b0;
  bit   hold_done = 0;

  function automatic int unsigned k_active();
    if (k_reg == 0) return 1;
    if (k_reg > MAX_K) return MAX_K;
    return k_reg;
  endfunction

  function automatic void bump(int unsigned p, int unsigned q, int unsigned g,
                               int unsigned h, int unsigned y, bit up);
    int unsigned b;
    b = ((g * MAX_K) + h) * 2 + y;
    link_cnt[b] = up ? link_cnt[b] + 1'b1 : link_cnt[b] - 1'b1;
    member_cnt[p*MAX_K+g] = up ? member_cnt[p*MAX_K+g] + 1'b1 : member_cnt[p*MAX_K+g] - 1'b1;
    member_cnt[q*MAX_K+h] = up ? member_cnt[q*MAX_K+h] + 1'b1 : member_cnt[q*MAX_K+h] - 1'b1;
  endfunction

  function automatic out_item_t sample_pair(in_item_t it);
    out_item_t r;
    int unsigned p, q, y, k, g, h, idx, sp, sq, i;
    longint unsigned w [MAX_K*MAX_K];
    longint unsigned u, total, run, thr, b0, b1, num, den, ratio, fp, fq, prior_y;
    p = it.sender; q = it.receiver; y = it.link; u = it.random_draw;
    sp = (p * MAX_USERS + q) * 2;
    sq = (q * MAX_USERS + p) * 2 + 1;
    r = '0;
    if (p == q) begin
      r.skipped = 1'b1;
      n_skip++;
      return r;
    end
    k = k_active();
    if (it.operation == OP_INIT) begin
      idx = (u * longint'(k * k)) >> 32;
    end else begin
      n_resample++;
      bump(p, q, assign_mem[sp] % MAX_K, assign_mem[sq] % MAX_K, y, 0);
      prior_y = y ? prior_pres : prior_abs;
      total = 0;
      for (g = 0; g < k; g++) begin
        for (h = 0; h < k; h++) begin
          b0 = link_cnt[((g*MAX_K)+h)*2];
          b1 = link_cnt[((g*MAX_K)+h)*2+1];
          num = (y ? b1 : b0) * 256 + prior_y;
          den = (b0 + b1) * 256 + prior_abs + prior_pres;
          ratio = (den != 0) ? (num << 24) / den : 0;
          fp = member_cnt[p*MAX_K+g] * 256 + memb_prior;
          fq = member_cnt[q*MAX_K+h] * 256 + memb_prior;
          w[g*k+h] = (ratio * fp * fq) >> 16;
          total += w[g*k+h];
        end
      end
      thr = (total >> 32) * u + (((total & 64'hFFFF_FFFF) * u) >> 32);
      idx = 0;
      run = 0;
      for (i = 0; i < k * k; i++) begin
        run += w[i];
        if (run > thr) begin
          idx = i;
          break;
        end
      end
    end
    g = idx / k;
    h = idx % k;
    assign_mem[sp] = g;
    assign_mem[sq] = h;
    bump(p, q, g, h, y, 1);
    r.sender_cluster = g;
    r.receiver_cluster = h;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, n_out);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        cluster_pick_q.push_back(sample_pair(in_data));
        n_acc++;
      end
      if (in_valid && in_stall) begin
        // hold the stalled transfer
      end else if (gap > 0) begin
        gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
        gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_out++;
        if (cluster_pick_q.size() == 0) begin
          report("unexpected transfer", 1, 0);
        end else begin
          if (out_data.sender_cluster != cluster_pick_q[0].sender_cluster)
            report("sender_cluster", out_data.sender_cluster,
                   cluster_pick_q[0].sender_cluster);
          if (out_data.receiver_cluster != cluster_pick_q[0].receiver_cluster)
            report("receiver_cluster", out_data.receiver_cluster,
                   cluster_pick_q[0].receiver_cluster);
          if (out_data.skipped != cluster_pick_q[0].skipped)
            report("skipped", out_data.skipped, cluster_pick_q[0].skipped);
          void'(cluster_pick_q.pop_front());
        end
      end
      if (hold_req && !hold_done) begin
        hold_done = 1;
        stall_cnt = 400;
      end
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < 70) begin
        out_stall <= 1'b0;
      end else begin
        stall_cnt = pick_gap();
        out_stall <= 1'b1;
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CFG_CLUSTER_COUNT:    k_reg = val[KCNT_W-1:0];
      CFG_PRIOR_ABSENT:     prior_abs = val;
      CFG_PRIOR_PRESENT:    prior_pres = val;
      CFG_MEMBERSHIP_PRIOR: memb_prior = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic add_item(logic op, int unsigned p, int unsigned q, logic y,
                          logic [31:0] u);
    in_item_t it;
    it.operation = op;
    it.sender = p;
    it.receiver = q;
    it.link = y;
    it.random_draw = u;
    if (p != q && op == OP_INIT) pair_seeded[p][q] = 1;
    pending_items.push_back(it);
    n_added++;
  endtask

  task automatic add_random(int unsigned n);
    int unsigned i, p, q, r;
    logic [31:0] u;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      p = (r < 50) ? $urandom_range(0, 7) : $urandom_range(0, 63);
      q = ($urandom_range(0, 99) < 50) ? $urandom_range(0, 7) : $urandom_range(0, 63);
      if ($urandom_range(0, 19) == 0) q = p;
      r = $urandom_range(0, 19);
      u = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
      if (p == q)
        add_item($urandom_range(0, 1), p, q, $urandom_range(0, 1), u);
      else if (pair_seeded[p][q] && $urandom_range(0, 99) < 65)
        add_item(OP_RESAMPLE, p, q, $urandom_range(0, 1), u);
      else
        add_item(OP_INIT, p, q, $urandom_range(0, 1), u);
    end
  endtask

  task automatic drain();
    while (n_out < n_added)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  int unsigned ph;
  logic [15:0] set_k [PHASES] = '{3, 1, 2, 8, 0, 15, 4, 5};
  logic [15:0] set_a [PHASES] = '{26, 0, 65535, 0, 256, 65535, 1, 400};
  logic [15:0] set_b [PHASES] = '{26, 0, 1, 0, 256, 65535, 700, 3};
  logic [15:0] set_m [PHASES] = '{26, 65535, 0, 0, 128, 65535, 9, 1000};
  int unsigned set_n [PHASES] = '{300, 250, 300, 120, 250, 120, 330, 330};

  initial begin
    k_reg = RST_CLUSTER_COUNT;
    prior_abs = RST_PRIOR;
    prior_pres = RST_PRIOR;
    memb_prior = RST_PRIOR;
    foreach (assign_mem[i]) assign_mem[i] = '0;
    foreach (link_cnt[i]) link_cnt[i] = '0;
    foreach (member_cnt[i]) member_cnt[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: equal users, field extremes, init then resample
    add_item(OP_INIT, 5, 5, 1'b0, 32'h1234_5678);
    add_item(OP_RESAMPLE, 63, 63, 1'b1, 32'hFFFF_FFFF);
    add_item(OP_INIT, 0, 63, 1'b0, 32'h0);
    add_item(OP_INIT, 63, 0, 1'b1, 32'hFFFF_FFFF);
    add_item(OP_RESAMPLE, 0, 63, 1'b0, 32'hFFFF_FFFF);
    add_item(OP_RESAMPLE, 63, 0, 1'b1, 32'h0);
    add_item(OP_INIT, 1, 2, 1'b1, 32'h8000_0000);
    add_item(OP_INIT, 1, 2, 1'b1, 32'h5555_5555);
    add_item(OP_RESAMPLE, 1, 2, 1'b1, 32'hAAAA_AAAA);
    add_item(OP_RESAMPLE, 1, 2, 1'b0, 32'h7FFF_FFFF);
    add_item(OP_INIT, 42, 21, 1'b0, 32'hC000_0001);
    add_item(OP_RESAMPLE, 42, 21, 1'b0, 32'h0000_0001);
    drain();

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        cfg_write(CFG_CLUSTER_COUNT, set_k[ph]);
        cfg_write(CFG_PRIOR_ABSENT, set_a[ph]);
        cfg_write(CFG_PRIOR_PRESENT, set_b[ph]);
        cfg_write(CFG_MEMBERSHIP_PRIOR, set_m[ph]);
      end
      if (ph == 1) hold_req <= 1'b1;
      add_random(set_n[ph]);
      drain();
    end

    if (cluster_pick_q.size() > 0) report("results missing", 0, cluster_pick_q.size());
    $display("%0d items accepted (%0d resamples, %0d equal-user skips), %0d results",
             n_acc, n_resample, n_skip, n_out);
    $display("%0d register settings, cluster counts 0 to 15, priors 0 to 65535",
             PHASES);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
